@@ rtl/union_find_rem_splicing_assert.svh @@
// Assertion macros shared by the checker; clocked on clk, held off in reset.
`ifndef UNION_FIND_REM_SPLICING_ASSERT_SVH
`define UNION_FIND_REM_SPLICING_ASSERT_SVH

// same-cycle implication
`define UFRS_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ufrs assertion failed");

// next-cycle implication
`define UFRS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ufrs assertion failed");

`endif

@@ rtl/ufrs_pkg.sv @@
package ufrs_pkg;

    localparam int ID_W = 16;
    localparam logic [15:0] COUNT_MAX = 16'hFFFF;

    typedef struct packed {
        logic [ID_W-1:0] node_a;
        logic [ID_W-1:0] node_b;
    } in_t;

    typedef struct packed {
        logic        merged;
        logic [15:0] forest_edges;
    } out_t;

    // controller -> datapath
    typedef struct packed {
        logic clear;   // write one entry of the init sweep
        logic load;    // take the edge beat
        logic update;  // write parent of the smaller side, move that walker up
        logic finish;  // register the result
        logic merge;   // result reports a merge
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic clr_last;
        logic in_range;
        logic same;     // both walkers see the same parent
        logic at_root;  // smaller-side walker is a root
    } sts_t;

endpackage

@@ rtl/union_find_rem_splicing.sv @@
// Rem's union-find with splicing over a parent memory of min(NODES, 65536) entries.
// After reset, busy stays high while the memory is swept so that every node is its
// own parent. An edge beat is taken when start is high and busy low; the block then
// walks in steps (each one parent read pair and at most one write on the two-read,
// one-write parent memory), and its result is registered onto done/result at the end
// of the last step. done is high for exactly one cycle and cannot be held off; busy
// drops in that same cycle, so the next edge may be started there. Ids not below NODES
// are ignored and report no merge with the unchanged count, which saturates at 65535.
module union_find_rem_splicing
#(
    parameter int NODES = 65536
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  ufrs_pkg::in_t  req,
    output logic           done,
    output ufrs_pkg::out_t result
);

    ufrs_pkg::cmd_t cmd;
    ufrs_pkg::sts_t sts;

    ufrs_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .sts   (sts),
        .cmd   (cmd)
    );

    ufrs_dpath
    #(
        .NODES (NODES)
    )
    u_dpath
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (req),
        .cmd    (cmd),
        .sts    (sts),
        .done   (done),
        .result (result)
    );

endmodule

@@ rtl/ufrs_ctrl.sv @@
module ufrs_ctrl
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  ufrs_pkg::sts_t sts,
    output ufrs_pkg::cmd_t cmd
);

    typedef enum logic [2:0]
    {
        ST_CLEAR = 3'b001,
        ST_IDLE  = 3'b010,
        ST_EVAL  = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                if (!sts.in_range || sts.same)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    cmd.update = 1'b1;
                    if (sts.at_root)
                    begin
                        // root links to the other parent: sets merge
                        cmd.finish = 1'b1;
                        cmd.merge  = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

@@ rtl/ufrs_dpath.sv @@
module ufrs_dpath
#(
    parameter int NODES = 65536
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  ufrs_pkg::in_t  req,
    input  ufrs_pkg::cmd_t cmd,
    output ufrs_pkg::sts_t sts,
    output logic           done,
    output ufrs_pkg::out_t result
);

    // ids are 16 bits, so entries beyond 65536 are never reached
    localparam int DEPTH = (NODES < 65536) ? NODES : 65536;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam logic [24:0] NODES_W = 25'(NODES);

    logic [ADDR_W-1:0] mem [DEPTH];

    logic [ADDR_W-1:0] x_reg, x_next;
    logic [ADDR_W-1:0] y_reg, y_next;
    logic [ADDR_W-1:0] pa_reg;
    logic [ADDR_W-1:0] pb_reg;
    logic [ADDR_W-1:0] clr_reg;
    logic              in_range_reg;
    logic [15:0]       count_reg, count_next;
    logic              done_reg;
    ufrs_pkg::out_t    result_reg;

    logic              a_small;
    logic [ADDR_W-1:0] s_node;
    logic [ADDR_W-1:0] s_par;
    logic [ADDR_W-1:0] o_par;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] wr_data;
    logic              req_in_range;

    assign a_small = (pa_reg < pb_reg);
    assign s_node  = a_small ? x_reg : y_reg;
    assign s_par   = a_small ? pa_reg : pb_reg;
    assign o_par   = a_small ? pb_reg : pa_reg;

    assign sts.clr_last = (clr_reg == ADDR_W'(DEPTH - 1));
    assign sts.in_range = in_range_reg;
    assign sts.same     = (pa_reg == pb_reg);
    assign sts.at_root  = (s_par == s_node);

    assign req_in_range = ({9'd0, req.node_a} < NODES_W) && ({9'd0, req.node_b} < NODES_W);

    // walker addresses double as the read addresses of the next cycle
    always_comb
    begin
        x_next = x_reg;
        y_next = y_reg;
        if (cmd.load)
        begin
            x_next = req.node_a[ADDR_W-1:0];
            y_next = req.node_b[ADDR_W-1:0];
        end
        else if (cmd.update)
        begin
            if (a_small)
            begin
                x_next = pa_reg;
            end
            else
            begin
                y_next = pb_reg;
            end
        end
    end

    assign wr_en   = cmd.clear || cmd.update;
    assign wr_addr = cmd.clear ? clr_reg : s_node;
    assign wr_data = cmd.clear ? clr_reg : o_par;

    assign count_next = (count_reg == ufrs_pkg::COUNT_MAX) ? count_reg : count_reg + 16'd1;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        pa_reg <= mem[x_next];
        pb_reg <= mem[y_next];
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        y_reg <= y_next;
        if (cmd.load)
        begin
            in_range_reg <= req_in_range;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg    <= '0;
            count_reg  <= '0;
            done_reg   <= 1'b0;
            result_reg <= '0;
        end
        else
        begin
            done_reg <= cmd.finish;
            if (cmd.clear)
            begin
                clr_reg <= clr_reg + ADDR_W'(1);
            end
            if (cmd.finish)
            begin
                result_reg.merged       <= cmd.merge;
                result_reg.forest_edges <= cmd.merge ? count_next : count_reg;
                if (cmd.merge)
                begin
                    count_reg <= count_next;
                end
            end
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

@@ rtl/ufrs_checker.sv @@
`include "union_find_rem_splicing_assert.svh"

module ufrs_checker
(
    input logic           clk,
    input logic           rst_n,
    input logic           start,
    input logic           busy,
    input logic           done,
    input ufrs_pkg::out_t result
);

    logic        accept;
    logic [15:0] last_edges_reg;
    logic        merge_count_ok;

    assign accept = start && !busy;

    always_ff @(posedge clk)
    begin
        last_edges_reg <= result.forest_edges;
    end

    assign merge_count_ok = (result.forest_edges == ufrs_pkg::COUNT_MAX) ||
                            (result.forest_edges == last_edges_reg + 16'd1);

    // an edge needs an accept and a walk before its result beat
    `UFRS_ASSERT_NEXT(a_done_single, done, !done)
    `UFRS_ASSERT_NEXT(a_busy_after_accept, accept, busy)
    // the count only moves with a result beat
    `UFRS_ASSERT_SAME(a_count_held, !done, $stable(result.forest_edges))
    `UFRS_ASSERT_SAME(a_nomerge_count, done && !result.merged, $stable(result.forest_edges))
    `UFRS_ASSERT_SAME(a_merge_count, done && result.merged, merge_count_ok)

endmodule

bind union_find_rem_splicing ufrs_checker u_chk (.*);
